// ----- design/kmt_pkg.sv -----
// ----------------------------------------------------------------------------
// kmt_pkg: shared types and constants of the keyed minimum tracker
// Holds the field widths, the operation codes, and the structs that
// travel along the row of slot cells.
// ----------------------------------------------------------------------------
package kmt_pkg;

    // Fixed widths of the item fields.
    localparam int VALUE_W       = 32;
    localparam int OWNER_ID_W    = 16;
    localparam int ENTRY_COUNT_W = 5;

    // Operation codes carried by the mode field.
    localparam logic MODE_ADD  = 1'b0;
    localparam logic MODE_DROP = 1'b1;

    // Operation broadcast to every cell while an item is in progress.
    typedef struct packed {
        logic               sample;   // cells latch their owner match
        logic               mode;     // operation code
        logic               any_hit;  // some valid slot matches the owner
        logic [VALUE_W-1:0] value;    // value to store on add
    } t_bcast;

    // Token handed from one cell to the next, one cell per cycle.
    typedef struct packed {
        logic               go;       // token is present this cycle
        logic               placed;   // a free slot has already been claimed
        logic               any;      // at least one valid slot seen so far
        logic [VALUE_W-1:0] min;      // running minimum of valid values
    } t_tok;

endpackage

// ----- design/kmt_cell.sv -----
// ----------------------------------------------------------------------------
// kmt_cell: one slot of the keyed minimum tracker
// Stores one owner and value with a valid bit. It compares its owner in
// parallel with the other cells, then updates its slot when the token
// passes and folds its value into the running minimum and count.
// ----------------------------------------------------------------------------
module kmt_cell #(
    parameter int OWNER_BITS = 16,
    parameter int CNT_W      = 5
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  kmt_pkg::t_bcast        i_bc,
    input  logic [OWNER_BITS-1:0]  i_owner,
    input  kmt_pkg::t_tok          i_tok,
    input  logic [CNT_W-1:0]       i_cnt,
    output kmt_pkg::t_tok          o_tok,
    output logic [CNT_W-1:0]       o_cnt,
    output logic                   o_match
);
    import kmt_pkg::*;

    logic                  r_valid;
    logic                  n_valid;
    logic [OWNER_BITS-1:0] r_owner;
    logic [OWNER_BITS-1:0] n_owner;
    logic [VALUE_W-1:0]    r_value;
    logic [VALUE_W-1:0]    n_value;
    logic                  r_match;
    t_tok                  r_tok;
    t_tok                  n_tok;
    logic [CNT_W-1:0]      r_cnt;
    logic [CNT_W-1:0]      n_cnt;
    logic                  is_add;
    logic                  claim;

    // Slot update when the token arrives, and the folded running results.
    always_comb begin
        is_add  = (i_bc.mode == MODE_ADD);
        claim   = is_add && !i_bc.any_hit && !i_tok.placed && !r_valid;
        n_valid = r_valid;
        n_owner = r_owner;
        n_value = r_value;
        if (i_tok.go) begin
            if (claim) begin
                n_valid = 1'b1;
                n_owner = i_owner;
            end
            if (is_add && (r_match || claim)) begin
                n_value = i_bc.value;
            end
            if (!is_add && r_match) begin
                n_valid = 1'b0;
            end
        end

        n_tok        = i_tok;
        n_tok.placed = i_tok.placed || claim;
        n_cnt        = i_cnt;
        if (n_valid) begin
            n_cnt     = i_cnt + CNT_W'(1);
            n_tok.any = 1'b1;
            if (!i_tok.any || (n_value < i_tok.min)) begin
                n_tok.min = n_value;
            end
        end
    end

    // Control state: valid bit and the token handed to the next cell.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_tok   <= '0;
        end else begin
            r_valid <= n_valid;
            r_tok   <= n_tok;
        end
    end

    // Slot contents, match flag and running count.
    always_ff @(posedge i_clk) begin
        r_owner <= n_owner;
        r_value <= n_value;
        r_cnt   <= n_cnt;
        if (i_bc.sample) begin
            r_match <= r_valid && (r_owner == i_owner);
        end
    end

    assign o_tok   = r_tok;
    assign o_cnt   = r_cnt;
    assign o_match = r_match;

endmodule

// ----- design/keyed_minimum_tracker.sv -----
// ----------------------------------------------------------------------------
// keyed_minimum_tracker: table of per-owner values with minimum report
// An item moves through the match, reduce and walk states; in the walk the token
// passes the row of SLOTS cells one cell per cycle. A new item is taken only once
// the last result has moved to the output register, which i_ready can hold back.
// A finished result waits in the output register while the next item runs.
// Reset (synchronous, active low) clears all valid bits: the table is empty.
// ----------------------------------------------------------------------------
module keyed_minimum_tracker #(
    parameter int SLOTS      = 16,
    parameter int OWNER_BITS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic                                 i_mode,
    input  logic [kmt_pkg::OWNER_ID_W-1:0]       i_owner_id,
    input  logic [kmt_pkg::VALUE_W-1:0]          i_value,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic [kmt_pkg::VALUE_W-1:0]          o_min_value,
    output logic [kmt_pkg::ENTRY_COUNT_W-1:0]    o_entry_count,
    output logic                                 o_changed,
    output logic                                 o_table_full
);
    import kmt_pkg::*;

    localparam int CNT_W = $clog2(SLOTS + 1);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_MATCH  = 5'b00010,
        S_REDUCE = 5'b00100,
        S_WALK   = 5'b01000,
        S_DONE   = 5'b10000
    } t_state;

    t_state                r_state;
    t_state                n_state;
    logic                  r_mode;
    logic [OWNER_BITS-1:0] r_owner;
    logic [VALUE_W-1:0]    r_value;
    logic                  r_any_hit;
    logic                  r_launch;
    logic [VALUE_W-1:0]    r_res_min;
    logic [CNT_W-1:0]      r_res_cnt;
    logic                  r_res_placed;
    logic                  r_o_valid;
    logic [VALUE_W-1:0]    r_o_min;
    logic [ENTRY_COUNT_W-1:0] r_o_cnt;
    logic                  r_o_changed;
    logic                  r_o_full;

    t_bcast                bc;
    t_tok                  tok [0:SLOTS];
    logic [CNT_W-1:0]      cnt [0:SLOTS];
    logic [SLOTS-1:0]      match;
    logic                  load_out;
    logic                  is_add;

    // Broadcast of the current operation to every cell.
    always_comb begin
        bc.sample  = (r_state == S_MATCH);
        bc.mode    = r_mode;
        bc.any_hit = r_any_hit;
        bc.value   = r_value;
    end

    // Token entering the first cell.
    always_comb begin
        tok[0].go     = r_launch;
        tok[0].placed = 1'b0;
        tok[0].any    = 1'b0;
        tok[0].min    = '0;
        cnt[0]        = '0;
    end

    // Row of slot cells.
    for (genvar g = 0; g < SLOTS; g++) begin : g_cell
        kmt_cell #(
            .OWNER_BITS (OWNER_BITS),
            .CNT_W      (CNT_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_bc    (bc),
            .i_owner (r_owner),
            .i_tok   (tok[g]),
            .i_cnt   (cnt[g]),
            .o_tok   (tok[g+1]),
            .o_cnt   (cnt[g+1]),
            .o_match (match[g])
        );
    end

    assign is_add   = (r_mode == MODE_ADD);
    assign load_out = (r_state == S_DONE) && (!r_o_valid || i_ready);

    // Sequencer for one item at a time.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_MATCH;
                end
            end
            S_MATCH:  n_state = S_REDUCE;
            S_REDUCE: n_state = S_WALK;
            S_WALK: begin
                if (tok[SLOTS].go) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_launch  <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_launch <= (r_state == S_REDUCE);
            if (load_out) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Item capture, owner-hit reduction and result registers.
    always_ff @(posedge i_clk) begin
        if ((r_state == S_IDLE) && i_valid) begin
            r_mode  <= i_mode;
            r_owner <= OWNER_BITS'(i_owner_id);
            r_value <= i_value;
        end
        if (r_state == S_REDUCE) begin
            r_any_hit <= |match;
        end
        if ((r_state == S_WALK) && tok[SLOTS].go) begin
            r_res_min    <= tok[SLOTS].min;
            r_res_cnt    <= cnt[SLOTS];
            r_res_placed <= tok[SLOTS].placed;
        end
        if (load_out) begin
            r_o_min     <= r_res_min;
            r_o_cnt     <= ENTRY_COUNT_W'(r_res_cnt);
            r_o_changed <= is_add || r_any_hit;
            r_o_full    <= is_add && !r_any_hit && !r_res_placed;
        end
    end

    assign o_ready       = (r_state == S_IDLE);
    assign o_valid       = r_o_valid;
    assign o_min_value   = r_o_min;
    assign o_entry_count = r_o_cnt;
    assign o_changed     = r_o_changed;
    assign o_table_full  = r_o_full;

endmodule

// ----- design/kmt_checker.sv -----
// ----------------------------------------------------------------------------
// kmt_checker: port-level checks for the keyed minimum tracker
// Watches the handshake and result fields over time and is bound to the
// top level.
// ----------------------------------------------------------------------------
module kmt_checker #(
    parameter int SLOTS = 16
) (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_valid,
    input logic                               o_ready,
    input logic                               o_valid,
    input logic                               i_ready,
    input logic [kmt_pkg::VALUE_W-1:0]        o_min_value,
    input logic [kmt_pkg::ENTRY_COUNT_W-1:0]  o_entry_count,
    input logic                               o_changed,
    input logic                               o_table_full
);
    import kmt_pkg::*;

    // A stalled result beat holds its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_min_value)
            && $stable(o_entry_count) && $stable(o_changed) && $stable(o_table_full))
        else $error("result beat changed while stalled");

    // Only one item is in progress: an accepted beat drops ready.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("input accepted while an item is in progress");

    // A rejected add still counts as a change.
    a_full_changed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_table_full |-> o_changed)
        else $error("table full reported without change");

    // A rejected add means every slot is taken.
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_table_full |-> o_entry_count == ENTRY_COUNT_W'(SLOTS))
        else $error("table full reported with free slots");

    // An empty table reports a zero minimum.
    a_empty_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_entry_count == '0) && (SLOTS < 32) |-> o_min_value == '0)
        else $error("nonzero minimum on empty table");

endmodule

bind keyed_minimum_tracker kmt_checker #(.SLOTS(SLOTS)) u_kmt_checker (.*);
